// File: src/wsa_pkg.sv
package wsa_pkg;

    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 20;
    localparam int HELD_W   = 5;
    localparam int FRAC_W   = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_HOLD
    } wsa_state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic out_load;
    } wsa_cmd_t;

    typedef struct packed {
        logic div_last;
    } wsa_sts_t;

endpackage

// File: src/wsa_ram.sv
module wsa_ram
#(
    parameter int WIDTH = 12,
    parameter int DEPTH = 30
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/wsa_ctrl.sv
module wsa_ctrl
    import wsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output wsa_cmd_t cmd,
    input  wsa_sts_t sts
);

    wsa_state_t state_reg;
    wsa_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    // output register is free when empty or its beat is taken this cycle
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/wsa_dp.sv
module wsa_dp
    import wsa_pkg::*;
#(
    parameter int WINDOW = 30
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] adc_sample,
    output logic [AVG_W-1:0]    average_q8,
    output logic [HELD_W-1:0]   samples_held,
    input  wsa_cmd_t            cmd,
    output wsa_sts_t            sts
);

    localparam int SW = $clog2(WINDOW);
    localparam int HW = $clog2(WINDOW + 1);
    localparam int TW = $clog2(WINDOW * 4095 + 1);
    localparam int DW = TW + FRAC_W;
    localparam int CW = $clog2(DW + 1);

    logic [SW-1:0]       slot_reg;
    logic [SW-1:0]       slot_next;
    logic                filled_reg;
    logic                filled_next;
    logic [TW-1:0]       total_reg;
    logic [TW-1:0]       total_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] old_sample;
    logic [HW-1:0]       held_reg;
    logic [HW-1:0]       held_next;
    logic [HW-1:0]       rem_reg;
    logic [HW-1:0]       rem_next;
    logic [DW-1:0]       dvd_reg;
    logic [DW-1:0]       dvd_next;
    logic [CW-1:0]       cnt_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic [HELD_W-1:0]   held_out_reg;
    logic                wrap;
    logic [HW:0]         trial;
    logic [HW+1:0]       diff;
    logic [HW+HELD_W-1:0] held_ext;

    wsa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.update),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (cmd.capture),
        .rd_addr (slot_reg),
        .rd_data (old_sample)
    );

    assign wrap        = (slot_reg == SW'(WINDOW - 1));
    assign slot_next   = wrap ? '0 : slot_reg + 1'b1;
    assign filled_next = filled_reg | wrap;
    // drop the oldest entry only once the ring has wrapped
    assign total_next  = total_reg
                         - (filled_reg ? TW'(old_sample) : '0)
                         + TW'(sample_reg);
    assign held_next   = filled_next ? HW'(WINDOW) : HW'(slot_reg) + 1'b1;

    // restoring divider, one quotient bit per cycle
    assign trial    = {rem_reg, dvd_reg[DW-1]};
    assign diff     = {1'b0, trial} - {2'b00, held_reg};
    assign rem_next = diff[HW+1] ? trial[HW-1:0] : diff[HW-1:0];
    assign dvd_next = {dvd_reg[DW-2:0], ~diff[HW+1]};

    assign held_ext     = {{HELD_W{1'b0}}, held_reg};
    assign sts.div_last = (cnt_reg == CW'(DW - 1));
    assign average_q8   = avg_reg;
    assign samples_held = held_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            filled_reg <= 1'b0;
            total_reg  <= '0;
        end
        else if (cmd.update)
        begin
            slot_reg   <= slot_next;
            filled_reg <= filled_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= adc_sample;
        end
        if (cmd.update)
        begin
            dvd_reg  <= {total_next, {FRAC_W{1'b0}}};
            rem_reg  <= '0;
            held_reg <= held_next;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            avg_reg      <= dvd_reg[AVG_W-1:0];
            held_out_reg <= held_ext[HELD_W-1:0];
        end
    end

endmodule

// File: src/windowed_sample_average_unit.sv
// boxcar average over a ring of WINDOW samples, with partial fill before first wrap
// the input beat goes through the capture, update, divide and hold states, the divide
// state running the one-bit-per-cycle restoring divider, before the result beat is valid
// a new input beat waits until the previous result is loaded into the output register
// reset clears write slot, fill flag, running total and output valid; ring is not cleared
module windowed_sample_average_unit
    import wsa_pkg::*;
#(
    parameter int WINDOW = 30
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] adc_sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [AVG_W-1:0]    average_q8,
    output logic [HELD_W-1:0]   samples_held
);

    wsa_cmd_t cmd;
    wsa_sts_t sts;

    wsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    wsa_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .adc_sample   (adc_sample),
        .average_q8   (average_q8),
        .samples_held (samples_held),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// File: verif/windowed_sample_average_unit_tb.sv
module windowed_sample_average_unit_tb
    import wsa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN         = 30;
    localparam int TOTAL_W     = $clog2(WIN * 4095 + 1);
    localparam int NUM_RANDOM  = 1600;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE      = 40;

    typedef struct {
        logic [AVG_W-1:0]  avg;
        logic [HELD_W-1:0] held;
    } mean_beat_t;

    class window_mean_tracker;
        logic [SAMPLE_W-1:0] ring [WIN];
        int unsigned         slot;
        bit                  filled;
        logic [TOTAL_W-1:0]  total;
        mean_beat_t          pending_means [$];
        int unsigned         mismatches;

        function new();
            slot       = 0;
            filled     = 1'b0;
            total      = '0;
            mismatches = 0;
        endfunction

        // running sum over the ring, mean over the samples held so far
        function void take_sample(logic [SAMPLE_W-1:0] s);
            mean_beat_t  b;
            logic [31:0] held;
            logic [31:0] scaled;
            if (filled)
            begin
                total -= ring[slot];
            end
            ring[slot] = s;
            total += s;
            slot++;
            if (slot == WIN)
            begin
                slot   = 0;
                filled = 1'b1;
            end
            held   = filled ? WIN : slot;
            scaled = 32'(total) << FRAC_W;
            b.avg  = AVG_W'(scaled / held);
            b.held = HELD_W'(held);
            pending_means.push_back(b);
        endfunction

        function void check_mean(logic [AVG_W-1:0] avg, logic [HELD_W-1:0] held);
            mean_beat_t b;
            if (pending_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: average_q8=%0d samples_held=%0d",
                             avg, held);
                return;
            end
            b = pending_means.pop_front();
            if (avg !== b.avg || held !== b.held)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch at %0t: avg exp %0d got %0d, held exp %0d got %0d",
                             $realtime, b.avg, avg, b.held, held);
            end
        endfunction

        function int unsigned pending();
            return pending_means.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] adc_sample = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [AVG_W-1:0]    average_q8;
    logic [HELD_W-1:0]   samples_held;

    bit calm = 1'b0;

    window_mean_tracker tracker = new();

    windowed_sample_average_unit #(
        .WINDOW (WIN)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average_q8   (average_q8),
        .samples_held (samples_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 9);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.take_sample(adc_sample);
            if (out_valid && !out_stall)
                tracker.check_mean(average_q8, samples_held);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        in_valid   <= 1'b1;
        adc_sample <= s;
        do @(posedge clk); while (in_stall);
        if (!calm && $urandom_range(99) < 9)
        begin
            in_valid   <= 1'b0;
            adc_sample <= SAMPLE_W'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned mode);
        case (mode)
            0: return SAMPLE_W'($urandom_range(4095));
            1: return 12'hFFF;
            2: return SAMPLE_W'($urandom_range(15));
            3: return 12'hFFF - SAMPLE_W'($urandom_range(15));
            4: return $urandom_range(1) ? ~(12'h1 << $urandom_range(11))
                                        : (12'h1 << $urandom_range(11));
            default: return $urandom_range(1) ? 12'hFFF : 12'h000;
        endcase
    endfunction

    initial
    begin
        logic [SAMPLE_W-1:0] directed [25];
        int unsigned         mode;
        int unsigned         waited;

        directed = '{12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h001, 12'hAAA, 12'h555,
                     12'h800, 12'h7FF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000,
                     12'hFFE, 12'h002, 12'h400, 12'hBFF, 12'h123, 12'hEDC, 12'hFFF,
                     12'h000, 12'hFFF, 12'h000, 12'hFFF};
        mode = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // partial fill: held count climbs from one
        foreach (directed[i])
            send_sample(directed[i]);
        drain();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 40 == 0)
                mode = $urandom_range(5);
            calm = (i >= 700 && i < 1000);
            if (i == 1200)
                drain();
            send_sample(pick_sample(mode));
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // let the last accepted beat reach the scoreboard first
        @(posedge clk);
        waited = 0;
        while (tracker.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
